FILE: src/lpr_pkg.sv
// Shared types and constants for the LRU page replacement block.
package lpr_pkg;

    localparam int PAGE_W     = 16;
    localparam int FRAME_W    = 4;
    localparam int FAULT_W    = 32;
    localparam int CFG_W      = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic [FAULT_W-1:0] t_fault;
    typedef logic [CFG_W-1:0]   t_cfg;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

FILE: src/lpr_if.sv
// Handshake channel interfaces for page references, results and configuration.
interface lpr_in_if import lpr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_page page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface lpr_out_if import lpr_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   hit;
    t_frame frame_index;
    logic   evicted_valid;
    t_page  evicted_page;
    t_fault fault_count;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input fault_count, output ready);
endinterface

interface lpr_cfg_if import lpr_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/lpr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module lpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/lru_page_replacement.sv
// Top level of the fully associative LRU page replacement block.
//
// Each page reference accepted on the input channel is looked up among the
// first frame_count frames (0 acts as 1, values above FRAMES act as FRAMES).
// A hit refreshes the recency of the lowest-numbered matching frame; a miss
// counts a saturating fault and fills the lowest empty active frame, or else
// replaces the least recently used active frame and reports the page it held.
// Page tags live in a RAM with one read port, so the lookup scans the active
// frames one per cycle; a new reference is accepted only after the previous
// one has finished its scan and been written to the output register.
// A finished result sits in an output register, and the next reference is
// accepted while that result still waits to be taken. The frame count may be
// written only while the block is idle; the configuration channel is always
// ready. Valid bits and recency ranks are kept in flip-flops cleared by reset,
// so the block needs no clearing pass after reset.
module lru_page_replacement import lpr_pkg::*; #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpr_in_if.sink     i_in,
    lpr_out_if.source  o_out,
    lpr_cfg_if.sink    i_cfg
);
    // Index width of a frame, width of the active count, stored tag width and
    // width of a recency rank.
    localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int ACT_W  = $clog2(FRAMES + 1);
    localparam int PW     = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int RW     = FIDX_W;

    typedef logic [FIDX_W-1:0] t_fidx;
    typedef logic [RW-1:0]     t_rank;
    typedef logic [PW-1:0]     t_tag;

    // Control state.
    t_state r_state, n_state;
    t_cfg   r_frame_count;
    logic   r_issued_all;
    logic   r_cv;
    logic   r_hit;
    logic   r_empty;
    logic   r_out_valid;
    logic   r_valid [FRAMES];
    t_rank  r_rank  [FRAMES];
    t_fault r_fault;

    // Datapath registers of the item in flight.
    t_tag   r_page;
    t_fidx  r_idx;
    t_fidx  r_ci;
    t_fidx  r_hit_idx;
    t_rank  r_hit_rank;
    t_fidx  r_empty_idx;
    t_fidx  r_best_idx;
    t_rank  r_best_rank;
    t_tag   r_best_page;

    // Result register.
    logic   r_o_hit;
    t_frame r_o_frame;
    logic   r_o_ev_valid;
    t_page  r_o_ev_page;

    logic [ACT_W-1:0] act;
    t_fidx  last_idx;
    logic   in_acc;
    logic   out_take;
    logic   issuing;
    t_tag   ram_rdata;
    logic   cmp_vb;
    t_rank  cmp_rank;
    logic   cmp_match;
    logic   best_upd;
    logic   fin;
    t_fidx  sel_frame;
    t_rank  sel_rank;
    logic   was_valid;
    t_fault fault_next;

    // Clamp the programmed frame count into 1..FRAMES.
    always_comb begin
        if (r_frame_count == '0) begin
            act = ACT_W'(1);
        end else if (32'(r_frame_count) > 32'(FRAMES)) begin
            act = ACT_W'(FRAMES);
        end else begin
            act = ACT_W'(r_frame_count);
        end
    end
    assign last_idx = FIDX_W'(act - ACT_W'(1));

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && (r_state == S_IDLE);
    assign out_take    = r_out_valid && o_out.ready;
    assign issuing     = (r_state == S_SCAN) && !r_issued_all;

    // The tag RAM is read one frame per cycle during the scan and written once
    // when a miss installs the new page. The write lands before the next scan
    // can start, so no forwarding is needed.
    lpr_ram #(
        .WIDTH (PW),
        .DEPTH (FRAMES)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (fin && !r_hit),
        .i_waddr (sel_frame),
        .i_wdata (r_page),
        .i_re    (issuing),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Compare stage: the tag read last cycle meets the valid bit and rank of
    // the same frame.
    assign cmp_vb    = r_valid[r_ci];
    assign cmp_rank  = r_rank[r_ci];
    assign cmp_match = cmp_vb && (ram_rdata == r_page);
    assign best_upd  = (r_ci == '0) || (cmp_rank > r_best_rank);

    // Selection of the frame that receives the reference.
    assign fin        = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign sel_frame  = r_hit ? r_hit_idx : (r_empty ? r_empty_idx : r_best_idx);
    assign sel_rank   = r_hit ? r_hit_rank : r_best_rank;
    assign was_valid  = r_hit || !r_empty;
    assign fault_next = (!r_hit && (r_fault != '1)) ? r_fault + FAULT_W'(1) : r_fault;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cv && (r_ci == last_idx)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_count <= CFG_RESET;
            r_issued_all  <= 1'b0;
            r_cv          <= 1'b0;
            r_hit         <= 1'b0;
            r_empty       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_fault       <= '0;
            for (int j = 0; j < FRAMES; j++) begin
                r_valid[j] <= 1'b0;
                r_rank[j]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cv    <= issuing;
            if (i_cfg.valid) begin
                r_frame_count <= i_cfg.data;
            end
            if (in_acc) begin
                r_issued_all <= 1'b0;
                r_hit        <= 1'b0;
                r_empty      <= 1'b0;
            end else begin
                if (issuing && (r_idx == last_idx)) begin
                    r_issued_all <= 1'b1;
                end
                if (r_cv && cmp_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (r_cv && !cmp_vb && !r_empty) begin
                    r_empty <= 1'b1;
                end
            end
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            // Touching a frame ages the more recent valid frames by one; a
            // frame that was empty ages every valid frame.
            if (fin) begin
                r_fault <= fault_next;
                for (int j = 0; j < FRAMES; j++) begin
                    if (FIDX_W'(j) == sel_frame) begin
                        r_rank[j]  <= '0;
                        r_valid[j] <= 1'b1;
                    end else if (r_valid[j] && (!was_valid || (r_rank[j] < sel_rank))) begin
                        r_rank[j] <= RW'(r_rank[j] + RW'(1));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_page <= i_in.page[PW-1:0];
            r_idx  <= '0;
        end else if (issuing) begin
            r_idx <= FIDX_W'(r_idx + FIDX_W'(1));
        end
        r_ci <= r_idx;
        if (r_cv && cmp_match && !r_hit) begin
            r_hit_idx  <= r_ci;
            r_hit_rank <= cmp_rank;
        end
        if (r_cv && !cmp_vb && !r_empty) begin
            r_empty_idx <= r_ci;
        end
        if (r_cv && best_upd) begin
            r_best_idx  <= r_ci;
            r_best_rank <= cmp_rank;
            r_best_page <= ram_rdata;
        end
        if (fin) begin
            r_o_hit      <= r_hit;
            r_o_frame    <= FRAME_W'(sel_frame);
            r_o_ev_valid <= !r_hit && !r_empty;
            r_o_ev_page  <= (!r_hit && !r_empty) ? PAGE_W'(r_best_page) : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.hit           = r_o_hit;
    assign o_out.frame_index   = r_o_frame;
    assign o_out.evicted_valid = r_o_ev_valid;
    assign o_out.evicted_page  = r_o_ev_page;
    assign o_out.fault_count   = r_fault;
endmodule

FILE: src/lpr_chk.sv
// Port-level checker for the LRU page replacement block and its bind.
module lpr_chk import lpr_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input logic   i_hit,
    input t_frame i_frame_index,
    input logic   i_evicted_valid,
    input t_page  i_evicted_page,
    input t_fault i_fault_count
);
    t_fault r_last_fault;
    logic   out_acc;

    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_fault <= '0;
        end else if (out_acc) begin
            r_last_fault <= i_fault_count;
        end
    end

    // A result that is not taken stays offered with the same frame index and fault count.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frame_index)
            && $stable(i_fault_count))
        else $error("result changed while stalled");

    // A hit never evicts, and a result without an eviction reports page zero.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hit |-> !i_evicted_valid)
        else $error("hit reported an eviction");

    a_no_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_evicted_valid |-> i_evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    // The fault count holds on a hit and steps by one, saturating, on a miss.
    a_fault_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (i_hit && (i_fault_count == r_last_fault))
            || (!i_hit && (r_last_fault == '1) && (i_fault_count == r_last_fault))
            || (!i_hit && (r_last_fault != '1)
                && (i_fault_count == r_last_fault + FAULT_W'(1))))
        else $error("fault count out of step");
endmodule

bind lru_page_replacement lpr_chk u_lpr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_hit           (o_out.hit),
    .i_frame_index   (o_out.frame_index),
    .i_evicted_valid (o_out.evicted_valid),
    .i_evicted_page  (o_out.evicted_page),
    .i_fault_count   (o_out.fault_count)
);
